[src/tlbtf_pkg.sv]
// ---------------------------------------------------------------------------
// tlbtf_pkg
// Types and constants for the fully associative TLB with FIFO/LRU replacement.
// ---------------------------------------------------------------------------
`default_nettype none

package tlbtf_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  // configuration register indexes
  localparam logic [1:0] CFG_PAGE_SIZE_LOG2     = 2'd0;
  localparam logic [1:0] CFG_TABLE_ENTRIES_LOG2 = 2'd1;
  localparam logic [1:0] CFG_REPLACE_POLICY     = 2'd2;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [4:0] PSL_MIN   = 5'd4;
  localparam logic [4:0] PSL_MAX   = 5'd16;
  localparam logic [4:0] PSL_RESET = 5'd6;
  localparam logic [3:0] TEL_MIN   = 4'd1;
  localparam logic [3:0] TEL_MAX   = 4'd10;
  localparam logic [3:0] TEL_RESET = 4'd2;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned L2_W    = 10;
  localparam int unsigned CFG_W   = 5;

endpackage : tlbtf_pkg

`default_nettype wire

[src/tlb_translate_fifo_lru.sv]
// ---------------------------------------------------------------------------
// tlb_translate_fifo_lru
// Fully associative TLB: lookup, fill with FIFO/LRU eviction, flush.
// ---------------------------------------------------------------------------
// Path: the accepting edge loads the input register; the CAM match and entry
//   update then go into the result register, which drives the done_o strobe.
// Throughput: one transaction per cycle; busy_o stays low, the entry update
//   of one transaction is done before the next one is evaluated.
// Reset: asynchronous; all entries invalid, ranks zero, config at defaults.
// Results cannot be stalled; done_o marks each one for a single cycle.
`default_nettype none

module tlb_translate_fifo_lru #(
  parameter int unsigned TLB_ENTRIES = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [tlbtf_pkg::CFG_W-1:0]       cfg_wdata_i,
  // command
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [tlbtf_pkg::ADDR_W-1:0]      logical_address_i,
  input  wire logic [tlbtf_pkg::FRAME_W-1:0]     frame_number_i,
  input  wire logic                              mem_replaced_i,
  input  wire logic [tlbtf_pkg::ADDR_W-1:0]      victim_page_i,
  // result
  output logic                                   done_o,
  output logic                                   hit_o,
  output logic [tlbtf_pkg::ADDR_W-1:0]           physical_address_o,
  output logic [tlbtf_pkg::ADDR_W-1:0]           level1_index_o,
  output logic [tlbtf_pkg::L2_W-1:0]             level2_index_o,
  output logic [tlbtf_pkg::OFF_W-1:0]            page_offset_o,
  output logic                                   evicted_valid_o,
  output logic [tlbtf_pkg::ADDR_W-1:0]           evicted_page_o
);

  import tlbtf_pkg::*;

  localparam int unsigned N      = TLB_ENTRIES;
  localparam int unsigned RANK_W = (N > 1) ? $clog2(N) : 1;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(N - 1);

  // configuration
  logic [4:0] psl_cfg_q;
  logic [3:0] tel_cfg_q;
  logic       policy_q;

  // input register
  logic                 in_vld_q;
  action_e              act_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 mrep_q;
  logic [ADDR_W-1:0]    vpage_q;

  // entries
  logic [ADDR_W-1:0]    page_q  [N];
  logic [FRAME_W-1:0]   efrm_q  [N];
  logic [N-1:0]         valid_q, valid_d;
  logic [RANK_W-1:0]    rank_q  [N];
  logic [RANK_W-1:0]    rank_d  [N];
  logic [N-1:0]         wr_en;

  // result register
  logic                 done_q;
  logic                 hit_q, hit_d;
  logic [ADDR_W-1:0]    pa_q, pa_d;
  logic [ADDR_W-1:0]    l1_q, l1_d;
  logic [L2_W-1:0]      l2_q, l2_d;
  logic [OFF_W-1:0]     off_q, off_d;
  logic                 ev_vld_q, ev_vld_d;
  logic [ADDR_W-1:0]    ev_page_q, ev_page_d;

  // address split
  logic [4:0]           psl;
  logic [3:0]           tel;
  logic [ADDR_W-1:0]    page;
  logic [ADDR_W-1:0]    off_full;
  logic [ADDR_W-1:0]    l2_full;
  logic [ADDR_W+3:0]    frame_sh;
  logic [ADDR_W+3:0]    hit_frame_sh;

  // match and select
  logic [N-1:0]         hit_m;      // lookup match on original state
  logic [N-1:0]         vic_m;      // memory victim match
  logic [N-1:0]         valid1;     // after victim drop
  logic [RANK_W-1:0]    rank1 [N];
  logic [N-1:0]         fill_m;     // fill page match after victim drop
  logic [N-1:0]         inv1;
  logic [N-1:0]         free_oh;
  logic [N-1:0]         ev_oh;
  logic [N-1:0]         tgt_oh;
  logic                 full1;
  logic [RANK_W-1:0]    hit_rank;
  logic [RANK_W-1:0]    vic_rank;
  logic [FRAME_W-1:0]   hit_frame;
  logic [ADDR_W-1:0]    ev_page;

  assign busy_o = 1'b0;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psl_cfg_q <= PSL_RESET;
      tel_cfg_q <= TEL_RESET;
      policy_q  <= POLICY_FIFO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAGE_SIZE_LOG2:     psl_cfg_q <= cfg_wdata_i;
        CFG_TABLE_ENTRIES_LOG2: tel_cfg_q <= cfg_wdata_i[3:0];
        CFG_REPLACE_POLICY:     policy_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---- input register ------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      act_q   <= action_e'(action_i);
      addr_q  <= logical_address_i;
      frame_q <= frame_number_i;
      mrep_q  <= mem_replaced_i;
      vpage_q <= victim_page_i;
    end
  end

  // ---- address split -------------------------------------------------------
  always_comb begin
    priority if (psl_cfg_q < PSL_MIN) psl = PSL_MIN;
    else if (psl_cfg_q > PSL_MAX)      psl = PSL_MAX;
    else                               psl = psl_cfg_q;
    priority if (tel_cfg_q < TEL_MIN) tel = TEL_MIN;
    else if (tel_cfg_q > TEL_MAX)      tel = TEL_MAX;
    else                               tel = tel_cfg_q;
  end

  assign page     = addr_q >> psl;
  assign off_full = addr_q & ((32'd1 << psl) - 32'd1);
  assign l2_full  = page & ((32'd1 << tel) - 32'd1);

  // ---- CAM match, victim drop, slot choice ---------------------------------
  always_comb begin
    hit_rank  = '0;
    vic_rank  = '0;
    hit_frame = '0;
    for (int i = 0; i < N; i++) begin
      hit_m[i] = valid_q[i] && (page_q[i] == page);
      vic_m[i] = mrep_q && valid_q[i] && (page_q[i] == vpage_q);
      if (hit_m[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_frame = hit_frame | efrm_q[i];
      end
      if (vic_m[i]) vic_rank = vic_rank | rank_q[i];
    end
    valid1 = valid_q & ~vic_m;
    for (int i = 0; i < N; i++) begin
      if (vic_m[i])                              rank1[i] = '0;
      else if (valid1[i] && (|vic_m) && rank_q[i] > vic_rank)
        rank1[i] = rank_q[i] - RANK_W'(1);
      else                                        rank1[i] = rank_q[i];
    end
    ev_page = '0;
    for (int i = 0; i < N; i++) begin
      fill_m[i] = valid1[i] && (page_q[i] == page);
      // when full the ranks are 0..N-1, so the oldest holds the top rank
      ev_oh[i]  = valid1[i] && (rank1[i] == RANK_MAX);
      if (ev_oh[i]) ev_page = ev_page | page_q[i];
    end
    full1   = &valid1;
    inv1    = ~valid1;
    free_oh = inv1 & (~inv1 + N'(1));
    tgt_oh  = full1 ? ev_oh : free_oh;
  end

  assign frame_sh     = {{(ADDR_W+4-FRAME_W){1'b0}}, frame_q} << psl;
  assign hit_frame_sh = {{(ADDR_W+4-FRAME_W){1'b0}}, hit_frame} << psl;

  // ---- entry update and result ---------------------------------------------
  always_comb begin
    valid_d   = valid_q;
    rank_d    = rank_q;
    wr_en     = '0;
    hit_d     = 1'b0;
    pa_d      = '0;
    l1_d      = '0;
    l2_d      = '0;
    off_d     = '0;
    ev_vld_d  = 1'b0;
    ev_page_d = '0;
    if (in_vld_q) begin
      unique case (act_q)
        ACT_LOOKUP: begin
          l1_d  = page >> tel;
          l2_d  = l2_full[L2_W-1:0];
          off_d = off_full[OFF_W-1:0];
          if (|hit_m) begin
            hit_d = 1'b1;
            pa_d  = hit_frame_sh[ADDR_W-1:0] + off_full;
            if (policy_q == POLICY_LRU) begin
              for (int i = 0; i < N; i++) begin
                if (hit_m[i]) rank_d[i] = '0;
                else if (valid_q[i] && rank_q[i] < hit_rank)
                  rank_d[i] = rank_q[i] + RANK_W'(1);
              end
            end
          end
        end
        ACT_FILL: begin
          pa_d    = frame_sh[ADDR_W-1:0] + off_full;
          l1_d    = page >> tel;
          l2_d    = l2_full[L2_W-1:0];
          off_d   = off_full[OFF_W-1:0];
          valid_d = valid1;
          rank_d  = rank1;
          if (|fill_m) begin
            wr_en = fill_m;   // resident page: new frame, rank kept
          end else begin
            ev_vld_d  = full1;
            ev_page_d = full1 ? ev_page : '0;
            wr_en     = tgt_oh;
            for (int i = 0; i < N; i++) begin
              if (tgt_oh[i]) begin
                valid_d[i] = 1'b1;
                rank_d[i]  = '0;
              end else if (valid1[i]) begin
                rank_d[i] = rank1[i] + RANK_W'(1);
              end
            end
          end
        end
        ACT_FLUSH: begin
          valid_d = '0;
          for (int i = 0; i < N; i++) rank_d[i] = '0;
        end
        default: ;  // unused code: no state change, zero result
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      done_q  <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (wr_en[i]) begin
        page_q[i] <= page;
        efrm_q[i] <= frame_q;
      end
    end
    if (in_vld_q) begin
      hit_q     <= hit_d;
      pa_q      <= pa_d;
      l1_q      <= l1_d;
      l2_q      <= l2_d;
      off_q     <= off_d;
      ev_vld_q  <= ev_vld_d;
      ev_page_q <= ev_page_d;
    end
  end

  assign done_o             = done_q;
  assign hit_o              = hit_q;
  assign physical_address_o = pa_q;
  assign level1_index_o     = l1_q;
  assign level2_index_o     = l2_q;
  assign page_offset_o      = off_q;
  assign evicted_valid_o    = ev_vld_q;
  assign evicted_page_o     = ev_page_q;

  // ---- assertions ----------------------------------------------------------
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result strobe without a transaction");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> ($onehot0(hit_m) && $onehot0(vic_m)))
    else $error("page resident in more than one entry");

  a_evict_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && act_q == ACT_FILL && fill_m == '0 && full1) |-> $onehot(ev_oh))
    else $error("no unique oldest entry on a full TLB");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> !evicted_valid_o)
    else $error("hit and eviction in one result");

endmodule : tlb_translate_fifo_lru

`default_nettype wire

[tb/tlb_xlat_checker.sv]
// ---------------------------------------------------------------------------
// tlb_xlat_checker
// Watches the config, command and result channels of the TLB, keeps its own
// copy of the entries and registers, predicts every translation and compares
// each result against the oldest one still due.
// ---------------------------------------------------------------------------
module tlb_xlat_checker #(
  parameter int unsigned N_ENTRIES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [tlbtf_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [1:0]                     action_i,
  input  logic [tlbtf_pkg::ADDR_W-1:0]   logical_address_i,
  input  logic [tlbtf_pkg::FRAME_W-1:0]  frame_number_i,
  input  logic                           mem_replaced_i,
  input  logic [tlbtf_pkg::ADDR_W-1:0]   victim_page_i,
  input  logic                           done_i,
  input  logic                           hit_i,
  input  logic [tlbtf_pkg::ADDR_W-1:0]   physical_address_i,
  input  logic [tlbtf_pkg::ADDR_W-1:0]   level1_index_i,
  input  logic [tlbtf_pkg::L2_W-1:0]     level2_index_i,
  input  logic [tlbtf_pkg::OFF_W-1:0]    page_offset_i,
  input  logic                           evicted_valid_i,
  input  logic [tlbtf_pkg::ADDR_W-1:0]   evicted_page_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlbtf_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] phys;
    logic [ADDR_W-1:0] l1;
    logic [L2_W-1:0]   l2;
    logic [OFF_W-1:0]  off;
    logic              ev_valid;
    logic [ADDR_W-1:0] ev_page;
  } xlat_t;

  logic [4:0]         psl_reg;
  logic [3:0]         tel_reg;
  logic               policy_reg;

  logic [ADDR_W-1:0]  tag_page  [N_ENTRIES];
  logic [FRAME_W-1:0] tag_frame [N_ENTRIES];
  logic               tag_valid [N_ENTRIES];
  int                 tag_rank  [N_ENTRIES];

  xlat_t              xlat_due [$];

  function automatic int find_entry(logic [ADDR_W-1:0] pg);
    for (int i = 0; i < N_ENTRIES; i++)
      if (tag_valid[i] && tag_page[i] == pg) return i;
    return -1;
  endfunction

  // invalidate and close the rank gap left behind
  function automatic void retire_entry(int s);
    int r;
    r = tag_rank[s];
    tag_valid[s] = 1'b0;
    tag_rank[s]  = 0;
    for (int i = 0; i < N_ENTRIES; i++)
      if (tag_valid[i] && tag_rank[i] > r) tag_rank[i]--;
  endfunction

  function automatic void promote_entry(int s);
    int r;
    r = tag_rank[s];
    for (int i = 0; i < N_ENTRIES; i++)
      if (tag_valid[i] && i != s && tag_rank[i] < r) tag_rank[i]++;
    tag_rank[s] = 0;
  endfunction

  function automatic xlat_t translate(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                      logic [FRAME_W-1:0] frame, logic mrep,
                                      logic [ADDR_W-1:0] vpage);
    int unsigned       psl;
    int unsigned       tel;
    logic [ADDR_W-1:0] page;
    logic [ADDR_W-1:0] offset;
    xlat_t             res;
    int                s;
    int                count;
    int                oldest;
    int                free_slot;
    psl = (psl_reg < PSL_MIN) ? PSL_MIN : (psl_reg > PSL_MAX) ? PSL_MAX : psl_reg;
    tel = (tel_reg < TEL_MIN) ? TEL_MIN : (tel_reg > TEL_MAX) ? TEL_MAX : tel_reg;
    page   = addr >> psl;
    offset = addr & ((32'd1 << psl) - 32'd1);
    res    = '0;
    case (act)
      ACT_LOOKUP: begin
        res.l1  = page >> tel;
        res.l2  = L2_W'(page & ((32'd1 << tel) - 32'd1));
        res.off = OFF_W'(offset);
        s = find_entry(page);
        if (s >= 0) begin
          res.hit  = 1'b1;
          res.phys = (ADDR_W'(tag_frame[s]) << psl) + offset;
          if (policy_reg == POLICY_LRU) promote_entry(s);
        end
      end
      ACT_FILL: begin
        res.phys = (ADDR_W'(frame) << psl) + offset;
        res.l1   = page >> tel;
        res.l2   = L2_W'(page & ((32'd1 << tel) - 32'd1));
        res.off  = OFF_W'(offset);
        if (mrep) begin
          s = find_entry(vpage);
          if (s >= 0) retire_entry(s);
        end
        s = find_entry(page);
        if (s >= 0) begin
          // resident page: new frame, rank untouched
          tag_frame[s] = frame;
        end else begin
          count     = 0;
          oldest    = -1;
          free_slot = -1;
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (tag_valid[i]) begin
              count++;
              if (oldest < 0 || tag_rank[i] > tag_rank[oldest]) oldest = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (count >= N_ENTRIES && oldest >= 0) begin
            res.ev_valid = 1'b1;
            res.ev_page  = tag_page[oldest];
            retire_entry(oldest);
            free_slot = oldest;
          end
          if (free_slot >= 0) begin
            for (int i = 0; i < N_ENTRIES; i++)
              if (tag_valid[i]) tag_rank[i]++;
            tag_valid[free_slot] = 1'b1;
            tag_page[free_slot]  = page;
            tag_frame[free_slot] = frame;
            tag_rank[free_slot]  = 0;
          end
        end
      end
      ACT_FLUSH: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          tag_valid[i] = 1'b0;
          tag_rank[i]  = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    xlat_t exp_r;
    xlat_t got_r;
    if (!rst_ni) begin
      psl_reg    = PSL_RESET;
      tel_reg    = TEL_RESET;
      policy_reg = POLICY_FIFO;
      for (int i = 0; i < N_ENTRIES; i++) begin
        tag_valid[i] = 1'b0;
        tag_rank[i]  = 0;
      end
      xlat_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_SIZE_LOG2:     psl_reg    = cfg_wdata_i[4:0];
          CFG_TABLE_ENTRIES_LOG2: tel_reg    = cfg_wdata_i[3:0];
          CFG_REPLACE_POLICY:     policy_reg = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        xlat_due.push_back(translate(action_i, logical_address_i, frame_number_i,
                                     mem_replaced_i, victim_page_i));
      if (done_i) begin
        got_r = {hit_i, physical_address_i, level1_index_i, level2_index_i,
                 page_offset_i, evicted_valid_i, evicted_page_i};
        if (xlat_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result with no transaction outstanding: hit=%0b pa=%h",
                     $realtime, hit_i, physical_address_i);
          fail_count_o++;
        end else begin
          exp_r = xlat_due.pop_front();
          if (got_r !== exp_r) begin
            if (fail_count_o < 10)
              $display({"%0t: mismatch exp hit=%0b pa=%h l1=%h l2=%h off=%h ev=%0b/%h",
                        " | got hit=%0b pa=%h l1=%h l2=%h off=%h ev=%0b/%h"},
                       $realtime, exp_r.hit, exp_r.phys, exp_r.l1, exp_r.l2, exp_r.off,
                       exp_r.ev_valid, exp_r.ev_page, got_r.hit, got_r.phys, got_r.l1,
                       got_r.l2, got_r.off, got_r.ev_valid, got_r.ev_page);
            fail_count_o++;
          end
        end
      end
      pending_o = xlat_due.size();
    end
  end

endmodule : tlb_xlat_checker

[tb/tlb_translate_fifo_lru_tb.sv]
// ---------------------------------------------------------------------------
// tlb_translate_fifo_lru_tb
// Drives lookups, fills and flushes into the TLB: a directed sequence for
// FIFO and LRU eviction corners, then random phases over several page and
// table sizes with and without sender idling. Checking is in the checker.
// ---------------------------------------------------------------------------
module tlb_translate_fifo_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbtf_pkg::*;

  localparam int unsigned N_ENTRIES       = 4;
  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned POOL_SIZE       = 6;

  // per phase: page size, table size, policy, sender idle percentage
  localparam logic [4:0]  PHASE_PSL  [N_PHASES] = '{4, 16, 0, 31, 8, 12, 6, 4};
  localparam logic [3:0]  PHASE_TEL  [N_PHASES] = '{1, 10, 15, 0, 5, 3, 2, 10};
  localparam logic        PHASE_POL  [N_PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1};
  localparam int unsigned PHASE_IDLE [N_PHASES] = '{0, 68, 0, 23, 68, 0, 23, 68};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          action_i;
  logic [ADDR_W-1:0]   logical_address_i;
  logic [FRAME_W-1:0]  frame_number_i;
  logic                mem_replaced_i;
  logic [ADDR_W-1:0]   victim_page_i;
  logic                done_o;
  logic                hit_o;
  logic [ADDR_W-1:0]   physical_address_o;
  logic [ADDR_W-1:0]   level1_index_o;
  logic [L2_W-1:0]     level2_index_o;
  logic [OFF_W-1:0]    page_offset_o;
  logic                evicted_valid_o;
  logic [ADDR_W-1:0]   evicted_page_o;

  int unsigned         fail_count;
  int unsigned         xlat_pending;
  int unsigned         cycle_count = 0;
  int unsigned         page_shift  = PSL_RESET;
  logic [ADDR_W-1:0]   page_pool [POOL_SIZE];

  tlb_translate_fifo_lru #(
    .TLB_ENTRIES (N_ENTRIES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .action_i           (action_i),
    .logical_address_i  (logical_address_i),
    .frame_number_i     (frame_number_i),
    .mem_replaced_i     (mem_replaced_i),
    .victim_page_i      (victim_page_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .physical_address_o (physical_address_o),
    .level1_index_o     (level1_index_o),
    .level2_index_o     (level2_index_o),
    .page_offset_o      (page_offset_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o)
  );

  tlb_xlat_checker #(
    .N_ENTRIES (N_ENTRIES)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .action_i           (action_i),
    .logical_address_i  (logical_address_i),
    .frame_number_i     (frame_number_i),
    .mem_replaced_i     (mem_replaced_i),
    .victim_page_i      (victim_page_i),
    .done_i             (done_o),
    .hit_i              (hit_o),
    .physical_address_i (physical_address_o),
    .level1_index_i     (level1_index_o),
    .level2_index_i     (level2_index_o),
    .page_offset_i      (page_offset_o),
    .evicted_valid_i    (evicted_valid_o),
    .evicted_page_i     (evicted_page_o),
    .fail_count_o       (fail_count),
    .pending_o          (xlat_pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // register writes only happen with nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_PAGE_SIZE_LOG2)
      page_shift = (data < PSL_MIN) ? PSL_MIN : (data > PSL_MAX) ? PSL_MAX : data;
  endtask

  task automatic drain_pipe();
    start_i = 1'b0;
    while (xlat_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                          input logic [FRAME_W-1:0] frame, input logic mrep,
                          input logic [ADDR_W-1:0] vpage);
    start_i           = 1'b1;
    action_i          = act;
    logical_address_i = addr;
    frame_number_i    = frame;
    mem_replaced_i    = mrep;
    victim_page_i     = vpage;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(logic [ADDR_W-1:0] pg);
    return (pg << page_shift) | ($urandom & ((32'd1 << page_shift) - 32'd1));
  endfunction

  task automatic refresh_pool();
    logic [ADDR_W-1:0] page_max;
    page_max     = 32'hFFFF_FFFF >> page_shift;
    page_pool[0] = page_max;
    page_pool[1] = '0;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = $urandom & page_max;
  endtask

  task automatic random_item(input int unsigned idle_pct);
    int unsigned       pick;
    logic [1:0]        act;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] vpage;
    logic              mrep;
    while ($urandom_range(99) < idle_pct) begin
      start_i           = 1'b0;
      action_i          = 2'($urandom);
      logical_address_i = $urandom;
      @(negedge clk_i);
    end
    pick = $urandom_range(99);
    act  = (pick < 48) ? ACT_LOOKUP : (pick < 90) ? ACT_FILL :
           (pick < 95) ? ACT_FLUSH : ACT_UNUSED;
    addr = ($urandom_range(99) < 85) ?
           page_addr(page_pool[$urandom_range(POOL_SIZE - 1)]) : $urandom;
    mrep  = (act == ACT_FILL) ? ($urandom_range(99) < 40) : 1'($urandom);
    vpage = ($urandom_range(99) < 70) ? page_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    send_cmd(act, addr, FRAME_W'($urandom), mrep, vpage);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    start_i           = 1'b0;
    action_i          = ACT_LOOKUP;
    logical_address_i = '0;
    frame_number_i    = '0;
    mem_replaced_i    = 1'b0;
    victim_page_i     = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: 64-byte pages, FIFO
    send_cmd(ACT_LOOKUP, 32'h0000_0000, '0, 1'b0, '0);
    send_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, '1, 1'b1, '1);
    send_cmd(ACT_FILL,   32'h0000_0040, 20'hFFFFF, 1'b0, '0);
    send_cmd(ACT_LOOKUP, 32'h0000_007F, '0, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_0085, 20'h00000, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_00C1, 20'h00002, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_0100, 20'h00003, 1'b0, '0);
    // full: oldest entry goes
    send_cmd(ACT_FILL,   32'h0000_0140, 20'h00005, 1'b0, '0);
    send_cmd(ACT_LOOKUP, 32'h0000_0040, '0, 1'b0, '0);
    // resident page gets a new frame, no eviction
    send_cmd(ACT_FILL,   32'h0000_0080, 20'h12345, 1'b0, '0);
    // memory victim resident, then not resident, then the filled page itself
    send_cmd(ACT_FILL,   32'h0000_0180, 20'h00006, 1'b1, 32'd3);
    send_cmd(ACT_FILL,   32'h0000_01C0, 20'h00007, 1'b1, 32'hFFFF_FFFF);
    send_cmd(ACT_FILL,   32'h0000_01C3, 20'h00077, 1'b1, 32'd7);
    send_cmd(ACT_UNUSED, 32'hDEAD_BEEF, 20'hABCDE, 1'b1, 32'd5);
    send_cmd(ACT_FLUSH,  32'h0000_0000, '0, 1'b0, '0);
    send_cmd(ACT_LOOKUP, 32'h0000_01C0, '0, 1'b0, '0);

    drain_pipe();
    write_reg(CFG_REPLACE_POLICY, CFG_W'(POLICY_LRU));
    send_cmd(ACT_FILL,   32'hFFFF_FFFF, 20'hFFFFF, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_0280, 20'h00010, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_02C0, 20'h00011, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_0300, 20'h00012, 1'b0, '0);
    // touch the first fill so the second one becomes least recent
    send_cmd(ACT_LOOKUP, 32'hFFFF_FFC0, '0, 1'b0, '0);
    send_cmd(ACT_FILL,   32'h0000_0340, 20'h00013, 1'b0, '0);
    send_cmd(ACT_LOOKUP, 32'h0000_02C5, '0, 1'b0, '0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_pipe();
      write_reg(CFG_PAGE_SIZE_LOG2, CFG_W'(PHASE_PSL[ph]));
      write_reg(CFG_TABLE_ENTRIES_LOG2, CFG_W'(PHASE_TEL[ph]));
      write_reg(CFG_REPLACE_POLICY, CFG_W'(PHASE_POL[ph]));
      refresh_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(PHASE_IDLE[ph]);
    end

    drain_pipe();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : tlb_translate_fifo_lru_tb

[tlb_translate_fifo_lru.f]
src/tlbtf_pkg.sv
src/tlb_translate_fifo_lru.sv
tb/tlb_xlat_checker.sv
tb/tlb_translate_fifo_lru_tb.sv
